/* src/rc4_pkg.sv */
// rc4_pkg: types and codes shared by the rc4 cipher modules
// no dependencies
package rc4_pkg;

	localparam logic [1:0] CMD_KEY   = 2'd0;
	localparam logic [1:0] CMD_SCHED = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;

	localparam int PERM_DEPTH = 256;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_SCHED = 2'd1,
		OP_DATA  = 2'd2
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] val;
	} item_t;

endpackage

/* src/rc4_ram.sv */
// rc4_ram: generic single write port, single read port ram with registered read
// no dependencies
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/rc4_fifo.sv */
// rc4_fifo: small register based first-in first-out queue
// no dependencies
module rc4_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* src/rc4_front.sv */
// rc4_front: accepts items, decodes the command and queues them for the engine
// depends on rc4_pkg and rc4_fifo
module rc4_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic [7:0]         byte_value,
	output rc4_pkg::item_t     item,
	output logic               item_empty,
	input  logic               item_pop
);

	import rc4_pkg::*;

	item_t dec_item;
	logic  dec_valid;

	always_comb begin
		dec_item.val = byte_value;
		dec_item.op  = OP_KEY;
		dec_valid    = 1'b1;
		case (command)
			CMD_KEY: begin
				dec_item.op = OP_KEY;
			end
			CMD_SCHED: begin
				dec_item.op = OP_SCHED;
			end
			CMD_DATA: begin
				dec_item.op = OP_DATA;
			end
			default: begin
				// unused command is dropped
				dec_valid = 1'b0;
			end
		endcase
	end

	rc4_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && dec_valid),
		.wdata (dec_item),
		.full  (full),
		.pop   (item_pop),
		.rdata (item),
		.empty (item_empty)
	);

endmodule

/* src/rc4_back.sv */
// rc4_back: key store, permutation memory and the schedule / keystream sequencer
// depends on rc4_pkg and rc4_ram
module rc4_back #(
	parameter int KEY_MAX = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rc4_pkg::item_t item,
	input  logic           item_empty,
	output logic           item_pop,
	input  logic           out_full,
	output logic           out_push,
	output logic [7:0]     out_data
);

	import rc4_pkg::*;

	localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CW = $clog2(KEY_MAX + 1);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_INIT    = 9'b000000010,
		ST_KS_RD_I = 9'b000000100,
		ST_KS_RD_J = 9'b000001000,
		ST_KS_WR1  = 9'b000010000,
		ST_KS_WR2  = 9'b000100000,
		ST_D_RD_J  = 9'b001000000,
		ST_D_WR1   = 9'b010000000,
		ST_D_WR2   = 9'b100000000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] key_count_q, key_count_d;
	logic [KW-1:0] k_q, k_d;
	logic [7:0]    n_q, n_d;
	logic [7:0]    i_q, i_d;
	logic [7:0]    j_q, j_d;
	logic [7:0]    si_q, si_d;
	logic [7:0]    sj_q, sj_d;
	logic [7:0]    t_q, t_d;
	logic [7:0]    val_q, val_d;

	logic          p_we, p_re;
	logic [7:0]    p_waddr, p_wdata, p_raddr, p_rdata;
	logic          k_we, k_re;
	logic [KW-1:0] k_waddr, k_raddr;
	logic [7:0]    k_wdata, k_rdata;
	logic [7:0]    key_byte;
	logic [7:0]    ks_byte;

	assign key_byte = (key_count_q == '0) ? 8'd0 : k_rdata;

	// keystream entry after the swap, with the two fresh writes bypassed
	assign ks_byte = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : p_rdata);

	always_comb begin
		state_d     = state_q;
		key_count_d = key_count_q;
		k_d         = k_q;
		n_d         = n_q;
		i_d         = i_q;
		j_d         = j_q;
		si_d        = si_q;
		sj_d        = sj_q;
		t_d         = t_q;
		val_d       = val_q;
		item_pop    = 1'b0;
		out_push    = 1'b0;
		out_data    = val_q ^ ks_byte;
		p_we        = 1'b0;
		p_waddr     = n_q;
		p_wdata     = n_q;
		p_re        = 1'b0;
		p_raddr     = n_q;
		k_we        = 1'b0;
		k_waddr     = key_count_q[KW-1:0];
		k_wdata     = item.val;
		k_re        = 1'b0;
		k_raddr     = k_q;
		case (state_q)
			ST_IDLE: begin
				if (!item_empty) begin
					item_pop = 1'b1;
					case (item.op)
						OP_KEY: begin
							if (key_count_q < CW'(KEY_MAX)) begin
								k_we        = 1'b1;
								key_count_d = key_count_q + CW'(1);
							end
						end
						OP_SCHED: begin
							n_d     = 8'd0;
							state_d = ST_INIT;
						end
						OP_DATA: begin
							i_d     = i_q + 8'd1;
							val_d   = item.val;
							p_re    = 1'b1;
							p_raddr = i_q + 8'd1;
							state_d = ST_D_RD_J;
						end
						default: begin
						end
					endcase
				end
			end
			ST_INIT: begin
				p_we = 1'b1;
				n_d  = n_q + 8'd1;
				if (n_q == 8'hFF) begin
					j_d     = 8'd0;
					k_d     = '0;
					state_d = ST_KS_RD_I;
				end
			end
			ST_KS_RD_I: begin
				p_re    = 1'b1;
				k_re    = 1'b1;
				state_d = ST_KS_RD_J;
			end
			ST_KS_RD_J: begin
				si_d    = p_rdata;
				j_d     = j_q + p_rdata + key_byte;
				p_re    = 1'b1;
				p_raddr = j_q + p_rdata + key_byte;
				state_d = ST_KS_WR1;
			end
			ST_KS_WR1: begin
				p_we    = 1'b1;
				p_wdata = p_rdata;
				state_d = ST_KS_WR2;
			end
			ST_KS_WR2: begin
				p_we    = 1'b1;
				p_waddr = j_q;
				p_wdata = si_q;
				if (CW'(k_q) + CW'(1) >= key_count_q) begin
					k_d = '0;
				end else begin
					k_d = k_q + KW'(1);
				end
				n_d = n_q + 8'd1;
				if (n_q == 8'hFF) begin
					i_d     = 8'd0;
					j_d     = 8'd0;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_KS_RD_I;
				end
			end
			ST_D_RD_J: begin
				si_d    = p_rdata;
				j_d     = j_q + p_rdata;
				p_re    = 1'b1;
				p_raddr = j_q + p_rdata;
				state_d = ST_D_WR1;
			end
			ST_D_WR1: begin
				sj_d    = p_rdata;
				t_d     = si_q + p_rdata;
				p_we    = 1'b1;
				p_waddr = i_q;
				p_wdata = p_rdata;
				p_re    = 1'b1;
				p_raddr = si_q + p_rdata;
				state_d = ST_D_WR2;
			end
			ST_D_WR2: begin
				if (!out_full) begin
					out_push = 1'b1;
					p_we     = 1'b1;
					p_waddr  = j_q;
					p_wdata  = si_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= '0;
			k_q         <= '0;
			n_q         <= 8'd0;
			i_q         <= 8'd0;
			j_q         <= 8'd0;
		end else begin
			state_q     <= state_d;
			key_count_q <= key_count_d;
			k_q         <= k_d;
			n_q         <= n_d;
			i_q         <= i_d;
			j_q         <= j_d;
		end
	end

	always_ff @(posedge clk) begin
		si_q  <= si_d;
		sj_q  <= sj_d;
		t_q   <= t_d;
		val_q <= val_d;
	end

	rc4_ram #(
		.WIDTH(8),
		.DEPTH(PERM_DEPTH),
		.AW   (8)
	) u_perm_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.re   (p_re),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	rc4_ram #(
		.WIDTH(8),
		.DEPTH(KEY_MAX),
		.AW   (KW)
	) u_key_ram (
		.clk  (clk),
		.we   (k_we),
		.waddr(k_waddr),
		.wdata(k_wdata),
		.re   (k_re),
		.raddr(k_raddr),
		.rdata(k_rdata)
	);

	a_key_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CW'(KEY_MAX))
		else $error("key count beyond capacity");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> state_q == ST_IDLE)
		else $error("item taken while engine busy");

	a_push_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |=> state_q == ST_IDLE)
		else $error("engine did not return to idle after a result");

	a_key_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KS_RD_I && key_count_q != '0) |-> CW'(k_q) < key_count_q)
		else $error("key index outside stored key");

endmodule

/* src/rc4_stream_cipher.sv */
// rc4_stream_cipher: top level of the rc4 cipher engine
// depends on rc4_pkg, rc4_front, rc4_back and rc4_fifo
//
// RC4 cipher engine with queue style ports on both sides. An item carries a
// command and a byte: command 0 appends a key byte (user key, then any IV
// bytes) to a store of KEY_MAX bytes, extra bytes are dropped; command 1 loads
// the identity permutation and runs the key schedule, then clears the generator
// indices; command 2 returns the byte XOR the next keystream byte; command 3 is
// dropped. Items go through a two entry queue to the engine, and results leave
// through a two entry queue. Once that queue is full of unpopped results the
// engine stalls, and once the item queue fills, full holds off the input. Behind the
// queue a key byte is stored from idle; for a data byte the two reads, the swap and
// the keystream read share the one port pair of the 256 entry permutation
// memory; a schedule is decoded, fills the memory, then reads S[i] and S[j] and
// writes both back for each of the 256 steps. Ciphering data before the first
// schedule is not defined.
module rc4_stream_cipher #(
	parameter int KEY_MAX = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] command,
	input  logic [7:0] byte_value,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte
);

	import rc4_pkg::*;

	item_t      mid_item;
	logic       mid_empty;
	logic       mid_pop;
	logic       res_full;
	logic       res_push;
	logic [7:0] res_data;

	rc4_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.byte_value(byte_value),
		.item      (mid_item),
		.item_empty(mid_empty),
		.item_pop  (mid_pop)
	);

	rc4_back #(
		.KEY_MAX(KEY_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (mid_item),
		.item_empty(mid_empty),
		.item_pop  (mid_pop),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_data  (res_data)
	);

	rc4_fifo #(
		.WIDTH(8),
		.DEPTH(2)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_data),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_byte),
		.empty (empty)
	);

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for rc4_stream_cipher, predicts every keystream byte
// depends on rc4_pkg and rc4_stream_cipher
// key, schedule and data items go through queue ports with random idling on both sides
`timescale 1ns / 1ps

module testbench;
	import rc4_pkg::*;

	localparam int KEY_CAP = 256;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 1400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [1:0] command = CMD_KEY;
	logic [7:0] byte_value = 8'h00;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [7:0] out_byte;

	// cipher state as the block should hold it
	logic [7:0] perm [0:255];
	logic [7:0] key_bytes [0:255];
	int key_len = 0;
	logic [7:0] gen_i = 8'h00;
	logic [7:0] gen_j = 8'h00;
	logic [7:0] expected_cipher [$];
	logic [7:0] got_want;

	bit steady = 1'b0;
	int failures = 0;
	int items_sent = 0;
	int n_data = 0, n_sched = 0, n_key = 0, n_dropped = 0, n_unused = 0, n_checked = 0;

	rc4_stream_cipher #(.KEY_MAX(KEY_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.byte_value(byte_value),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte)
	);

	always #4 clk = ~clk;

	function automatic bit idle_roll();
		return !steady && ($urandom_range(0, 99) < 38);
	endfunction

	task automatic cipher_step(input logic [1:0] cmd, input logic [7:0] val);
		logic [7:0] j, kb, tmp, t;
		case (cmd)
			CMD_KEY: begin
				if (key_len < KEY_CAP) begin
					key_bytes[key_len] = val;
					key_len++;
					n_key++;
					items_sent++;
				end else begin
					n_dropped++;
				end
			end
			CMD_SCHED: begin
				for (int n = 0; n < 256; n++)
					perm[n] = n[7:0];
				j = 8'h00;
				for (int n = 0; n < 256; n++) begin
					kb = (key_len == 0) ? 8'h00 : key_bytes[n % key_len];
					j = j + perm[n] + kb;
					tmp = perm[n];
					perm[n] = perm[j];
					perm[j] = tmp;
				end
				gen_i = 8'h00;
				gen_j = 8'h00;
				n_sched++;
				items_sent++;
			end
			CMD_DATA: begin
				gen_i = gen_i + 8'd1;
				gen_j = gen_j + perm[gen_i];
				tmp = perm[gen_i];
				perm[gen_i] = perm[gen_j];
				perm[gen_j] = tmp;
				t = perm[gen_i] + perm[gen_j];
				expected_cipher.push_back(val ^ perm[t]);
				n_data++;
				items_sent++;
			end
			default: begin
				n_unused++;
			end
		endcase
	endtask

	task automatic send_item(input logic [1:0] cmd, input logic [7:0] val);
		@(negedge clk);
		while (idle_roll()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		byte_value <= val;
		@(posedge clk);
		while (full)
			@(posedge clk);
		cipher_step(cmd, val);
	endtask

	always @(negedge clk)
		pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 38);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_cipher.size() == 0) begin
				$error("out_byte: no item expected, actual %02h", out_byte);
				failures++;
			end else begin
				got_want = expected_cipher.pop_front();
				n_checked++;
				if (out_byte !== got_want) begin
					$error("out_byte mismatch: expected %02h, actual %02h", got_want, out_byte);
					failures++;
				end
			end
		end
	end

	// empty key, extreme data bytes, unused command
	task automatic test_empty_key();
		send_item(CMD_UNUSED, 8'hFF);
		send_item(CMD_SCHED, 8'h00);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_UNUSED, 8'h00);
		send_item(CMD_DATA, 8'hA5);
		send_item(CMD_DATA, 8'h5A);
	endtask

	// short key, then a key byte appended after the schedule and a reschedule
	task automatic test_short_key();
		send_item(CMD_KEY, 8'h00);
		send_item(CMD_KEY, 8'hFF);
		send_item(CMD_KEY, 8'h80);
		send_item(CMD_KEY, 8'h01);
		send_item(CMD_SCHED, 8'hFF);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_DATA, 8'h0F);
		send_item(CMD_KEY, 8'h7E);
		send_item(CMD_DATA, 8'hF0);
		send_item(CMD_SCHED, 8'h00);
		send_item(CMD_DATA, 8'h55);
		send_item(CMD_DATA, 8'hAA);
		send_item(CMD_DATA, 8'h01);
	endtask

	// key bytes, schedule, run of data bytes, with stray key and unused items
	task automatic test_random_sessions(input int target);
		int n_new, n_run, roll;
		while (items_sent < target) begin
			steady = (items_sent > 600 && items_sent < 900);
			n_new = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			for (int k = 0; k < n_new; k++)
				send_item(CMD_KEY, 8'($urandom_range(0, 255)));
			send_item(CMD_SCHED, 8'($urandom_range(0, 255)));
			n_run = $urandom_range(20, 140);
			for (int k = 0; k < n_run; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
				else if (roll < 5)
					send_item(CMD_KEY, 8'($urandom_range(0, 255)));
				else
					send_item(CMD_DATA, 8'($urandom_range(0, 255)));
			end
		end
		steady = 1'b0;
	endtask

	// fill the key store, push extra key bytes that get dropped, then cipher
	task automatic test_key_overflow();
		while (key_len < KEY_CAP)
			send_item(CMD_KEY, 8'($urandom_range(0, 255)));
		for (int k = 0; k < 10; k++)
			send_item(CMD_KEY, 8'($urandom_range(0, 255)));
		send_item(CMD_SCHED, 8'($urandom_range(0, 255)));
		for (int k = 0; k < 120; k++)
			send_item(CMD_DATA, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_key();
		test_short_key();
		test_random_sessions(1350);
		test_key_overflow();
		@(negedge clk);
		push <= 1'b0;
		while (expected_cipher.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d data, %0d schedules, %0d key bytes, %0d dropped key bytes, %0d unused",
			n_data, n_sched, n_key, n_dropped, n_unused);
		$display("checked %0d cipher bytes, %0d failures", n_checked, failures);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout with %0d cipher bytes still expected", expected_cipher.size());
		$display("Verification failed");
		$finish;
	end

endmodule
